FILE: rtl/tlt_pkg.sv
// ----------------------------------------------------------------------------
// tlt_pkg: shared types and constants of the thread latency tracker.
// Request and response layouts, slot table entries, opcodes, FSM states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tlt_pkg;

  // Fixed field widths.
  localparam int SLOT_W = 12;
  localparam int TS_W   = 64;
  localparam int BKT_W  = 6;
  localparam int CNT_W  = 64;

  // Nanoseconds per microsecond.
  localparam logic [TS_W-1:0] NS_PER_US = 64'd1000;

  // The log2 search halves its step: 32, 16, 8, 4, 2, 1.
  localparam int unsigned LOG2_FIRST_SHIFT = 32;
  localparam int          LOG2_STEPS       = 6;
  localparam int          STEP_W           = 3;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_SWITCH = 2'd0,
    OP_WAKEUP = 2'd1,
    OP_READ   = 2'd2
  } tlt_op_e;

  // One request.
  typedef struct packed {
    logic [1:0]        opcode;
    logic [TS_W-1:0]   timestamp_ns;
    logic [SLOT_W-1:0] prev_slot;
    logic [SLOT_W-1:0] next_slot;
    logic              prev_blocked;
    logic [SLOT_W-1:0] wake_slot;
    logic [BKT_W-1:0]  bucket_select;
  } tlt_req_t;

  // One response.
  typedef struct packed {
    logic              sample_valid;
    logic [SLOT_W-1:0] sample_slot;
    logic [TS_W-1:0]   start_ns;
    logic [TS_W-1:0]   end_ns;
    logic [TS_W-1:0]   off_time_ns;
    logic              bucket_hit_valid;
    logic [BKT_W-1:0]  bucket_hit;
    logic [CNT_W-1:0]  bucket_count;
  } tlt_rsp_t;

  // One slot table entry: a recorded start time and its valid flag.
  typedef struct packed {
    logic            valid;
    logic [TS_W-1:0] time_ns;
  } tlt_entry_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_SEARCH,
    ST_HIST_RD,
    ST_HIST_WR
  } tlt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear_step;
    logic eval;
    logic search_step;
    logic hist_rd;
    logic hist_wr;
  } tlt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic wake_hit;
    logic search_last;
  } tlt_sts_t;

endpackage

FILE: rtl/tlt_ctrl.sv
// ----------------------------------------------------------------------------
// tlt_ctrl: sequencing state machine of the thread latency tracker.
// Runs the clearing pass after reset, takes requests and steps the datapath
// through evaluation, the log2 search and the histogram update.
// ----------------------------------------------------------------------------
module tlt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tlt_pkg::tlt_sts_t sts_i,
  output tlt_pkg::tlt_cmd_t cmd_o
);

  tlt_pkg::tlt_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlt_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlt_pkg::ST_CLEAR: begin
        if (sts_i.clear_last) state_d = tlt_pkg::ST_IDLE;
      end
      tlt_pkg::ST_IDLE: begin
        if (start) state_d = tlt_pkg::ST_EVAL;
      end
      tlt_pkg::ST_EVAL: begin
        state_d = sts_i.wake_hit ? tlt_pkg::ST_SEARCH : tlt_pkg::ST_IDLE;
      end
      tlt_pkg::ST_SEARCH: begin
        if (sts_i.search_last) state_d = tlt_pkg::ST_HIST_RD;
      end
      tlt_pkg::ST_HIST_RD: begin
        state_d = tlt_pkg::ST_HIST_WR;
      end
      tlt_pkg::ST_HIST_WR: begin
        state_d = tlt_pkg::ST_IDLE;
      end
      default: begin
        state_d = tlt_pkg::ST_CLEAR;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      tlt_pkg::ST_CLEAR:   cmd_o.clear_step = 1'b1;
      tlt_pkg::ST_IDLE: begin
        busy         = 1'b0;
        cmd_o.accept = start;
      end
      tlt_pkg::ST_EVAL:    cmd_o.eval = 1'b1;
      tlt_pkg::ST_SEARCH:  cmd_o.search_step = 1'b1;
      tlt_pkg::ST_HIST_RD: cmd_o.hist_rd = 1'b1;
      tlt_pkg::ST_HIST_WR: cmd_o.hist_wr = 1'b1;
      default:             cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/tlt_datapath.sv
// ----------------------------------------------------------------------------
// tlt_datapath: slot tables, log2 search unit and histogram of the tracker.
// Holds the off-CPU and blocked start tables, the bucket counters, the
// clearing counter and the response register.
// ----------------------------------------------------------------------------
module tlt_datapath #(
  parameter int THREAD_SLOTS = 4096,
  parameter int HIST_BUCKETS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tlt_pkg::tlt_req_t req_i,
  input  tlt_pkg::tlt_cmd_t cmd_i,
  output tlt_pkg::tlt_sts_t sts_o,
  output logic              done_o,
  output tlt_pkg::tlt_rsp_t rsp_o
);

  localparam int SLOT_AW   = $clog2(THREAD_SLOTS);
  localparam int HIST_AW   = $clog2(HIST_BUCKETS);
  localparam int CLR_DEPTH = (THREAD_SLOTS > HIST_BUCKETS) ? THREAD_SLOTS : HIST_BUCKETS;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int BW        = tlt_pkg::BKT_W;
  localparam int SW        = tlt_pkg::STEP_W;
  localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_DEPTH - 1);
  localparam logic [BW-1:0]    BKT_MAX   = BW'(HIST_BUCKETS - 1);
  localparam logic [SW-1:0]    STEP_LAST = SW'(tlt_pkg::LOG2_STEPS - 1);

  // True when a slot index falls inside the tables.
  function automatic logic slot_ok(input logic [tlt_pkg::SLOT_W-1:0] slot);
    return 32'(slot) < THREAD_SLOTS;
  endfunction

  // Storage.
  tlt_pkg::tlt_entry_t off_mem   [THREAD_SLOTS];
  tlt_pkg::tlt_entry_t sleep_mem [THREAD_SLOTS];
  logic [tlt_pkg::CNT_W-1:0] hist_mem [HIST_BUCKETS];

  tlt_pkg::tlt_req_t   req_q;
  tlt_pkg::tlt_entry_t off_rd_q, sleep_rd_q;
  logic [tlt_pkg::CNT_W-1:0] hist_rd_q;
  logic [CLR_W-1:0]    clr_q;
  logic [tlt_pkg::TS_W-1:0] delta_q, thr_q;
  logic [BW-1:0]       r_q;
  logic [SW-1:0]       step_q;
  logic                done_q;
  tlt_pkg::tlt_rsp_t   rsp_q;

  // Memory port signals.
  logic                      off_we, off_re, sleep_we, sleep_re, hist_we, hist_re;
  logic [SLOT_AW-1:0]        off_wa, off_ra, sleep_wa, sleep_ra;
  logic [HIST_AW-1:0]        hist_wa, hist_ra;
  tlt_pkg::tlt_entry_t       off_wd, sleep_wd;
  logic [tlt_pkg::CNT_W-1:0] hist_wd;

  // Decoded request and evaluation terms.
  logic              in_switch, in_wakeup, in_read;
  logic              prev_ok, next_ok, wake_ok, sel_ok;
  logic              sample_hit, clear_next, wake_hit, finish_eval;
  logic              clr_slot_ok, clr_hist_ok;
  logic [BW-1:0]     shift_amt, bucket;
  logic              take_step;
  tlt_pkg::tlt_rsp_t rsp_eval, rsp_wake;

  // Request decode at the accept edge.
  assign in_switch = cmd_i.accept && (req_i.opcode == tlt_pkg::OP_SWITCH);
  assign in_wakeup = cmd_i.accept && (req_i.opcode == tlt_pkg::OP_WAKEUP);
  assign in_read   = cmd_i.accept && (req_i.opcode == tlt_pkg::OP_READ);

  // Terms of the held request.
  assign prev_ok    = slot_ok(req_q.prev_slot);
  assign next_ok    = slot_ok(req_q.next_slot);
  assign wake_ok    = slot_ok(req_q.wake_slot);
  assign sel_ok     = 32'(req_q.bucket_select) < HIST_BUCKETS;
  assign sample_hit = (req_q.opcode == tlt_pkg::OP_SWITCH) && next_ok && off_rd_q.valid;
  // The outgoing slot was already rewritten at the accept edge; keep it when it is the same.
  assign clear_next = sample_hit && !(prev_ok && (req_q.prev_slot == req_q.next_slot));
  assign wake_hit   = (req_q.opcode == tlt_pkg::OP_WAKEUP) && wake_ok && sleep_rd_q.valid;
  assign finish_eval = cmd_i.eval && !wake_hit;

  // Clearing pass coverage.
  assign clr_slot_ok = 32'(clr_q) < THREAD_SLOTS;
  assign clr_hist_ok = 32'(clr_q) < HIST_BUCKETS;

  // Log2 search step: test whether the delta reaches the threshold shifted up.
  assign shift_amt = BW'(tlt_pkg::LOG2_FIRST_SHIFT >> step_q);
  assign take_step = (delta_q >> shift_amt) >= thr_q;
  assign bucket    = (r_q > BKT_MAX) ? BKT_MAX : r_q;

  // Off-CPU table port control.
  always_comb begin
    off_we = 1'b0;
    off_wa = '0;
    off_wd = '0;
    priority if (cmd_i.clear_step) begin
      off_we = clr_slot_ok;
      off_wa = SLOT_AW'(clr_q);
    end else if (in_switch) begin
      off_we = slot_ok(req_i.prev_slot);
      off_wa = SLOT_AW'(req_i.prev_slot);
      off_wd = '{valid: 1'b1, time_ns: req_i.timestamp_ns};
    end else if (cmd_i.eval) begin
      off_we = clear_next;
      off_wa = SLOT_AW'(req_q.next_slot);
    end
    off_re = in_switch && slot_ok(req_i.next_slot);
    off_ra = SLOT_AW'(req_i.next_slot);
  end

  // Blocked-start table port control.
  always_comb begin
    sleep_we = 1'b0;
    sleep_wa = '0;
    sleep_wd = '0;
    priority if (cmd_i.clear_step) begin
      sleep_we = clr_slot_ok;
      sleep_wa = SLOT_AW'(clr_q);
    end else if (in_switch) begin
      sleep_we = slot_ok(req_i.prev_slot) && req_i.prev_blocked;
      sleep_wa = SLOT_AW'(req_i.prev_slot);
      sleep_wd = '{valid: 1'b1, time_ns: req_i.timestamp_ns};
    end else if (cmd_i.eval) begin
      sleep_we = wake_hit;
      sleep_wa = SLOT_AW'(req_q.wake_slot);
    end
    sleep_re = in_wakeup && slot_ok(req_i.wake_slot);
    sleep_ra = SLOT_AW'(req_i.wake_slot);
  end

  // Histogram port control.
  always_comb begin
    hist_we = 1'b0;
    hist_wa = '0;
    hist_wd = '0;
    priority if (cmd_i.clear_step) begin
      hist_we = clr_hist_ok;
      hist_wa = HIST_AW'(clr_q);
    end else if (cmd_i.hist_wr) begin
      hist_we = 1'b1;
      hist_wa = HIST_AW'(bucket);
      hist_wd = hist_rd_q + 1'b1;
    end
    hist_re = 1'b0;
    hist_ra = '0;
    priority if (in_read) begin
      hist_re = 32'(req_i.bucket_select) < HIST_BUCKETS;
      hist_ra = HIST_AW'(req_i.bucket_select);
    end else if (cmd_i.hist_rd) begin
      hist_re = 1'b1;
      hist_ra = HIST_AW'(bucket);
    end
  end

  // Memories with registered, read-first outputs.
  always_ff @(posedge clk_i) begin
    if (off_we) off_mem[off_wa] <= off_wd;
    if (off_re) off_rd_q <= off_mem[off_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sleep_we) sleep_mem[sleep_wa] <= sleep_wd;
    if (sleep_re) sleep_rd_q <= sleep_mem[sleep_ra];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    if (hist_re) hist_rd_q <= hist_mem[hist_ra];
  end

  // Response of a request that finishes in the evaluation cycle.
  always_comb begin
    rsp_eval = '0;
    unique case (req_q.opcode)
      tlt_pkg::OP_SWITCH: begin
        if (sample_hit) begin
          rsp_eval.sample_valid = 1'b1;
          rsp_eval.sample_slot  = req_q.next_slot;
          rsp_eval.start_ns     = off_rd_q.time_ns;
          rsp_eval.end_ns       = req_q.timestamp_ns;
          rsp_eval.off_time_ns  = req_q.timestamp_ns - off_rd_q.time_ns;
        end
      end
      tlt_pkg::OP_READ: begin
        rsp_eval.bucket_hit   = req_q.bucket_select;
        rsp_eval.bucket_count = sel_ok ? hist_rd_q : '0;
      end
      default: begin
        rsp_eval = '0;
      end
    endcase
  end

  // Response of a wakeup that reached the histogram.
  always_comb begin
    rsp_wake = '0;
    rsp_wake.bucket_hit_valid = 1'b1;
    rsp_wake.bucket_hit       = bucket;
  end

  // Request hold register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) req_q <= req_i;
  end

  // Log2 search registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      delta_q <= req_q.timestamp_ns - sleep_rd_q.time_ns;
      thr_q   <= tlt_pkg::NS_PER_US;
      r_q     <= '0;
    end else if (cmd_i.search_step && take_step) begin
      thr_q <= thr_q << shift_amt;
      r_q   <= r_q + shift_amt;
    end
  end

  // Response register.
  always_ff @(posedge clk_i) begin
    if (finish_eval) begin
      rsp_q <= rsp_eval;
    end else if (cmd_i.hist_wr) begin
      rsp_q <= rsp_wake;
    end
  end

  // Control counters and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.eval) begin
        step_q <= '0;
      end else if (cmd_i.search_step) begin
        step_q <= step_q + 1'b1;
      end
      done_q <= finish_eval || cmd_i.hist_wr;
    end
  end

  // Status and outputs.
  assign sts_o.clear_last  = (clr_q == CLR_LAST);
  assign sts_o.wake_hit    = wake_hit;
  assign sts_o.search_last = (step_q == STEP_LAST);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

FILE: rtl/thread_latency_tracker_log2_histogram.sv
// ----------------------------------------------------------------------------
// thread_latency_tracker_log2_histogram: per-thread off-CPU and blocked time.
// Switch, read, unused-opcode and missed-wakeup requests: the evaluation state, then the
// registered result and a return to idle, ready for the next request.
// Wakeup with a blocked start: the evaluation state, the 6-step log2 search and the
// bucket read and write, then the registered result and a return to idle.
// done_o marks each result for one cycle; the receiver cannot stall it.
// After reset the clearing pass walks max(THREAD_SLOTS, HIST_BUCKETS) entries, busy high.
// ----------------------------------------------------------------------------
module thread_latency_tracker_log2_histogram #(
  parameter int THREAD_SLOTS = 4096,
  parameter int HIST_BUCKETS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tlt_pkg::tlt_req_t req_i,
  output logic              done_o,
  output tlt_pkg::tlt_rsp_t rsp_o
);

  tlt_pkg::tlt_cmd_t cmd;
  tlt_pkg::tlt_sts_t sts;

  // Sequencer.
  tlt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Tables, search unit and histogram.
  tlt_datapath #(
    .THREAD_SLOTS (THREAD_SLOTS),
    .HIST_BUCKETS (HIST_BUCKETS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

FILE: rtl/tlt_checker.sv
// ----------------------------------------------------------------------------
// tlt_checker: port-level checks of the thread latency tracker.
// Watches the request and response ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module tlt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input tlt_pkg::tlt_req_t req_i,
  input logic              done_o,
  input tlt_pkg::tlt_rsp_t rsp_o
);

  // The clearing pass holds requests off right after reset.
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> busy)
    else $error("tracker not busy when leaving reset");

  // A taken request keeps the block busy for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("tracker idle right after taking a request");

  // Every result follows a busy cycle.
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without preceding work");

  // A sample comes after its switch was taken and ends at that switch's time.
  a_sample_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.sample_valid) |->
      ($past(start && !busy, 2) && (rsp_o.end_ns == $past(req_i.timestamp_ns, 2))))
    else $error("sample end time does not match its switch request");

  // A sample never reports a histogram update or count.
  a_sample_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.sample_valid) |->
      (!rsp_o.bucket_hit_valid && (rsp_o.bucket_count == '0)))
    else $error("sample carries histogram fields");

endmodule

bind thread_latency_tracker_log2_histogram tlt_checker u_tlt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of thread_latency_tracker_log2_histogram.
// A queue-fed driver presents switch, wakeup, read and unused requests with
// random gaps. A scoreboard tracks the per-slot off-CPU and blocked start
// times and the log2 histogram, and checks every response field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int          SLOTS      = 4096;
  localparam int          BUCKETS    = 64;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam logic [63:0] NS_IN_US   = 64'd1000;
  localparam int          RAND_REQS  = 1900;
  localparam int          MAX_GAP    = 14;
  localparam int          DRAIN_WAIT = 30;
  localparam int          CYCLE_CAP  = 400000;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  tlt_pkg::tlt_req_t req;
  logic              done;
  tlt_pkg::tlt_rsp_t rsp;

  thread_latency_tracker_log2_histogram #(
    .THREAD_SLOTS(SLOTS),
    .HIST_BUCKETS(BUCKETS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done),
    .rsp_o (rsp)
  );

  // Requests waiting to be driven and responses still owed by the block.
  tlt_pkg::tlt_req_t pending_reqs[$];
  tlt_pkg::tlt_rsp_t owed_rsps[$];

  // Shadow copy of the slot tables and the histogram.
  bit          off_live    [SLOTS];
  logic [63:0] off_since   [SLOTS];
  bit          sleep_live  [SLOTS];
  logic [63:0] sleep_since [SLOTS];
  bit   [63:0] sleep_hist  [BUCKETS];

  int unsigned mismatches;
  int unsigned rsp_seen;
  int unsigned cycles;
  int unsigned n_switch, n_samples, n_wake, n_hits, n_reads, n_unused;
  int          gap_left;
  int          burst_left;
  logic        took;

  // Clock and a single reset pulse.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Index of the highest set bit, zero for zero.
  function automatic int msb_index(input logic [63:0] v);
    int idx;
    idx = 0;
    for (int k = 0; k < 64; k++) begin
      if (v[k]) idx = k;
    end
    return idx;
  endfunction

  // Apply one request to the shadow state and return the response it owes.
  function automatic tlt_pkg::tlt_rsp_t latency_response(input tlt_pkg::tlt_req_t r);
    tlt_pkg::tlt_rsp_t o;
    logic [63:0]       us;
    int                b;
    o = '0;
    case (r.opcode)
      tlt_pkg::OP_SWITCH: begin
        n_switch++;
        // The incoming slot is looked up and cleared before the outgoing one is recorded.
        if (r.next_slot < SLOTS && off_live[r.next_slot]) begin
          o.sample_valid = 1'b1;
          o.sample_slot  = r.next_slot;
          o.start_ns     = off_since[r.next_slot];
          o.end_ns       = r.timestamp_ns;
          o.off_time_ns  = r.timestamp_ns - off_since[r.next_slot];
          off_live[r.next_slot] = 1'b0;
          n_samples++;
        end
        if (r.prev_slot < SLOTS) begin
          off_live[r.prev_slot]  = 1'b1;
          off_since[r.prev_slot] = r.timestamp_ns;
          if (r.prev_blocked) begin
            sleep_live[r.prev_slot]  = 1'b1;
            sleep_since[r.prev_slot] = r.timestamp_ns;
          end
        end
      end
      tlt_pkg::OP_WAKEUP: begin
        n_wake++;
        if (r.wake_slot < SLOTS && sleep_live[r.wake_slot]) begin
          us = (r.timestamp_ns - sleep_since[r.wake_slot]) / NS_IN_US;
          b  = msb_index(us);
          if (b > BUCKETS - 1) b = BUCKETS - 1;
          sleep_hist[b] = sleep_hist[b] + 64'd1;
          sleep_live[r.wake_slot] = 1'b0;
          o.bucket_hit_valid = 1'b1;
          o.bucket_hit       = b[5:0];
          n_hits++;
        end
      end
      tlt_pkg::OP_READ: begin
        n_reads++;
        o.bucket_hit = r.bucket_select;
        if (r.bucket_select < BUCKETS) o.bucket_count = sleep_hist[r.bucket_select];
      end
      default: n_unused++;
    endcase
    return o;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    $display("tb: response %0d %s got %h expected %h", rsp_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) note_mismatch(what, got, want);
  endtask

  // Request builders: unused fields carry random bits.
  function automatic tlt_pkg::tlt_req_t noise_req();
    logic [127:0]      raw;
    tlt_pkg::tlt_req_t r;
    raw = {$urandom, $urandom, $urandom, $urandom};
    r   = raw[$bits(tlt_pkg::tlt_req_t)-1:0];
    return r;
  endfunction

  function automatic tlt_pkg::tlt_req_t make_switch(input logic [63:0] ts, input int prev,
                                                    input int next, input bit blocked);
    tlt_pkg::tlt_req_t r;
    r              = noise_req();
    r.opcode       = tlt_pkg::OP_SWITCH;
    r.timestamp_ns = ts;
    r.prev_slot    = prev[tlt_pkg::SLOT_W-1:0];
    r.next_slot    = next[tlt_pkg::SLOT_W-1:0];
    r.prev_blocked = blocked;
    return r;
  endfunction

  function automatic tlt_pkg::tlt_req_t make_wake(input logic [63:0] ts, input int slot);
    tlt_pkg::tlt_req_t r;
    r              = noise_req();
    r.opcode       = tlt_pkg::OP_WAKEUP;
    r.timestamp_ns = ts;
    r.wake_slot    = slot[tlt_pkg::SLOT_W-1:0];
    return r;
  endfunction

  function automatic tlt_pkg::tlt_req_t make_read(input int sel);
    tlt_pkg::tlt_req_t r;
    r               = noise_req();
    r.opcode        = tlt_pkg::OP_READ;
    r.bucket_select = sel[tlt_pkg::BKT_W-1:0];
    return r;
  endfunction

  // Sender gap per request, with occasional back-to-back bursts.
  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 60);
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Driver: inputs change on the falling edge, one request per handshake.
  always @(negedge clk_i) begin : drive
    logic              nxt_start;
    tlt_pkg::tlt_req_t nxt_req;
    nxt_start = start;
    nxt_req   = req;
    if (!rst_ni) begin
      nxt_start = 1'b0;
    end else begin
      if (start && took) begin
        nxt_start = 1'b0;
        gap_left  = draw_gap();
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          nxt_req   = pending_reqs.pop_front();
          nxt_start = 1'b1;
        end
      end
    end
    start <= nxt_start;
    req   <= nxt_req;
  end

  // Monitor: check a strobed response, then record an accepted request.
  always @(posedge clk_i) begin : watch
    tlt_pkg::tlt_rsp_t want;
    if (rst_ni && done === 1'b1) begin
      rsp_seen++;
      if (owed_rsps.size() == 0) begin
        note_mismatch("unexpected response", 64'd0, 64'd0);
      end else begin
        want = owed_rsps.pop_front();
        check_field("sample_valid", 64'(rsp.sample_valid), 64'(want.sample_valid));
        check_field("sample_slot", 64'(rsp.sample_slot), 64'(want.sample_slot));
        check_field("start_ns", rsp.start_ns, want.start_ns);
        check_field("end_ns", rsp.end_ns, want.end_ns);
        check_field("off_time_ns", rsp.off_time_ns, want.off_time_ns);
        check_field("bucket_hit_valid", 64'(rsp.bucket_hit_valid),
                    64'(want.bucket_hit_valid));
        check_field("bucket_hit", 64'(rsp.bucket_hit), 64'(want.bucket_hit));
        check_field("bucket_count", rsp.bucket_count, want.bucket_count);
      end
    end
    if (rst_ni && start && !busy) owed_rsps.push_back(latency_response(req));
    took <= rst_ni && start && !busy;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    logic [63:0]       now_ns;
    logic [63:0]       mask;
    int                hot [8];
    int                pick;
    tlt_pkg::tlt_req_t odd;

    start      = 1'b0;
    req        = '0;
    took       = 1'b0;
    gap_left   = 0;
    burst_left = 0;

    // Directed: empty reads, a wakeup with nothing blocked, slot extremes,
    // the same slot in and out, a wrapped off time, the longest blocked
    // time, the unused opcode and a second wakeup of a cleared slot.
    pending_reqs.push_back(make_read(0));
    pending_reqs.push_back(make_read(BUCKETS - 1));
    pending_reqs.push_back(make_wake(64'd100, 5));
    pending_reqs.push_back(make_switch(64'd0, 0, SLOTS - 1, 1'b1));
    pending_reqs.push_back(make_switch(64'd1000, SLOTS - 1, 0, 1'b0));
    pending_reqs.push_back(make_switch(64'd5, 7, 7, 1'b1));
    pending_reqs.push_back(make_switch(64'd10, 7, 7, 1'b0));
    pending_reqs.push_back(make_wake(64'd999, 0));
    pending_reqs.push_back(make_wake(64'd2005, 7));
    pending_reqs.push_back(make_switch(64'hFFFF_FFFF_FFFF_FFF0, 100, SLOTS - 1, 1'b1));
    pending_reqs.push_back(make_switch(64'h20, SLOTS - 1, 100, 1'b0));
    pending_reqs.push_back(make_wake(64'd2000, 100));
    pending_reqs.push_back(make_switch(64'd0, 200, 1, 1'b1));
    pending_reqs.push_back(make_wake(64'hFFFF_FFFF_FFFF_FFFF, 200));
    odd        = '1;
    odd.opcode = OP_UNUSED;
    pending_reqs.push_back(odd);
    pending_reqs.push_back(make_wake(64'd5000, 0));
    pending_reqs.push_back(make_read(1));
    pending_reqs.push_back(make_read(53));
    pending_reqs.push_back(make_read(0));
    pending_reqs.push_back(make_switch(64'hFFFF_FFFF_FFFF_FFFF, SLOTS - 1, SLOTS - 1, 1'b1));
    pending_reqs.push_back(make_wake(64'hFFFF_FFFF_FFFF_FFFF, SLOTS - 1));

    // Random: mostly a small set of busy slots on a rising clock, so that
    // samples and histogram hits are frequent; some wide slots and time jumps.
    now_ns = {$urandom, $urandom};
    for (int i = 0; i < RAND_REQS; i++) begin
      if (i % 200 == 0) begin
        foreach (hot[k]) hot[k] = $urandom_range(0, SLOTS - 1);
        hot[0] = 0;
        hot[1] = SLOTS - 1;
      end
      if ($urandom_range(0, 19) == 0) begin
        now_ns = {$urandom, $urandom};
      end else begin
        mask   = (64'd1 << $urandom_range(0, 34)) - 64'd1;
        now_ns = now_ns + ({$urandom, $urandom} & mask);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        pending_reqs.push_back(make_switch(now_ns, hot[$urandom_range(0, 7)],
          ($urandom_range(0, 9) == 0) ? $urandom_range(0, SLOTS - 1) : hot[$urandom_range(0, 7)],
          1'($urandom_range(0, 1))));
      end else if (pick < 78) begin
        pending_reqs.push_back(make_wake(now_ns,
          ($urandom_range(0, 9) == 0) ? $urandom_range(0, SLOTS - 1) : hot[$urandom_range(0, 7)]));
      end else if (pick < 96) begin
        pending_reqs.push_back(make_read($urandom_range(0, BUCKETS - 1)));
      end else begin
        odd        = noise_req();
        odd.opcode = OP_UNUSED;
        pending_reqs.push_back(odd);
      end
    end

    // Wait until every request is taken and every response has arrived.
    while (pending_reqs.size() != 0 || start) @(posedge clk_i);
    while (owed_rsps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("tb: %0d switches with %0d samples, %0d wakeups with %0d bucket hits",
             n_switch, n_samples, n_wake, n_hits);
    $display("tb: %0d bucket reads, %0d unused opcodes, %0d responses, %0d mismatches",
             n_reads, n_unused, rsp_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
